>>> src/efd_pkg.sv
package efd_pkg;

    localparam int INDEX_W = 16;

    localparam logic [15:0] TAG_GROUP     = 16'hFFFE;
    localparam logic [15:0] TAG_ITEM      = 16'hE000;
    localparam logic [15:0] TAG_SEQ_DELIM = 16'hE0DD;

    typedef enum logic [1:0] {
        ST_DELIM    = 2'd0,
        ST_RAN_OUT  = 2'd1,
        ST_BAD_TAG  = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_SKIP    = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0]         fragment_byte;
        logic               has_byte;
        logic [INDEX_W-1:0] fragment_index;
        logic               fragment_end;
        logic               done_res;
        status_t            end_status;
    } result_t;

endpackage

>>> src/efd_parser.sv
module efd_parser
    import efd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_fire,
    input  logic [31:0] cfg_data,
    input  logic        in_fire,
    input  logic [7:0]  data_byte,
    input  logic        region_start,
    output logic        res_valid,
    output result_t     res
);

    logic [31:0]        region_length_reg;
    phase_t             phase_reg, phase_next;
    logic [55:0]        header_reg, header_next;
    logic [2:0]         hcount_reg, hcount_next;
    logic [31:0]        offset_reg, offset_next;
    logic [31:0]        remain_reg, remain_next;
    logic               first_reg, first_next;
    logic [INDEX_W-1:0] count_reg, count_next;

    phase_t             ph;
    logic [55:0]        hdr;
    logic [2:0]         hcnt;
    logic [31:0]        rem;
    logic [31:0]        rem_dec;
    logic               first;
    logic [INDEX_W-1:0] cnt;
    logic [INDEX_W-1:0] cnt_inc;
    logic [31:0]        left;
    logic               left_ge8;
    logic [63:0]        full_hdr;
    logic [15:0]        grp;
    logic [15:0]        elem;
    logic [31:0]        len;
    logic               is_item;
    logic               len_gt_left;

    always_comb
    begin
        ph    = phase_reg;
        hdr   = header_reg;
        hcnt  = hcount_reg;
        rem   = remain_reg;
        first = first_reg;
        cnt   = count_reg;
        offset_next = offset_reg;
        if (region_start)
        begin
            ph          = PH_HEADER;
            hdr         = '0;
            hcnt        = '0;
            rem         = '0;
            first       = 1'b1;
            cnt         = '0;
            offset_next = '0;
        end
        offset_next = offset_next + 32'd1;

        left        = (region_length_reg > offset_next) ? region_length_reg - offset_next
                                                       : 32'd0;
        left_ge8    = (left >= 32'd8);
        full_hdr    = {data_byte, hdr};
        grp         = full_hdr[15:0];
        elem        = full_hdr[31:16];
        len         = full_hdr[63:32];
        is_item     = (grp == TAG_GROUP) && (elem == TAG_ITEM);
        len_gt_left = (len > left);
        cnt_inc     = (cnt != {INDEX_W{1'b1}}) ? cnt + 1'b1 : cnt;
        rem_dec     = (rem != 32'd0) ? rem - 32'd1 : 32'd0;

        phase_next  = ph;
        header_next = hdr;
        hcount_next = hcnt;
        remain_next = rem;
        first_next  = first;
        count_next  = cnt;
        res_valid   = 1'b0;
        res         = '0;
        res.fragment_index = cnt;

        if (region_start && (region_length_reg < 32'd8))
        begin
            // short region: byte is accepted but not parsed
            offset_next    = '0;
            phase_next     = PH_DONE;
            res_valid      = 1'b1;
            res.done_res   = 1'b1;
            res.end_status = ST_RAN_OUT;
        end
        else
        begin
            unique case (ph)
                PH_HEADER:
                begin
                    if (hcnt != 3'd7)
                    begin
                        for (int i = 0; i < 7; i++)
                        begin
                            if (hcnt == 3'(i))
                                header_next[8*i +: 8] = data_byte;
                        end
                        hcount_next = hcnt + 3'd1;
                    end
                    else
                    begin
                        header_next = '0;
                        hcount_next = '0;
                        if (first && is_item)
                        begin
                            first_next = 1'b0;
                            if (len_gt_left || ((len == 32'd0) && !left_ge8))
                            begin
                                phase_next     = PH_DONE;
                                res_valid      = 1'b1;
                                res.done_res   = 1'b1;
                                res.end_status = ST_RAN_OUT;
                            end
                            else if (len != 32'd0)
                            begin
                                remain_next = len;
                                phase_next  = PH_SKIP;
                            end
                        end
                        else
                        begin
                            first_next = 1'b0;
                            res_valid  = 1'b1;
                            priority if ((grp == TAG_GROUP) && (elem == TAG_SEQ_DELIM))
                            begin
                                phase_next     = PH_DONE;
                                res.done_res   = 1'b1;
                                res.end_status = ST_DELIM;
                            end
                            else if (!is_item)
                            begin
                                phase_next     = PH_DONE;
                                res.done_res   = 1'b1;
                                res.end_status = ST_BAD_TAG;
                            end
                            else if (len_gt_left)
                            begin
                                phase_next     = PH_DONE;
                                res.done_res   = 1'b1;
                                res.end_status = ST_TOO_LONG;
                            end
                            else if (len == 32'd0)
                            begin
                                // empty fragment
                                count_next       = cnt_inc;
                                res.fragment_end = 1'b1;
                                if (!left_ge8)
                                begin
                                    phase_next     = PH_DONE;
                                    res.done_res   = 1'b1;
                                    res.end_status = ST_RAN_OUT;
                                end
                            end
                            else
                            begin
                                res_valid   = 1'b0;
                                remain_next = len;
                                phase_next  = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    remain_next = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        phase_next  = PH_HEADER;
                        header_next = '0;
                        hcount_next = '0;
                        if (!left_ge8)
                        begin
                            phase_next     = PH_DONE;
                            res_valid      = 1'b1;
                            res.done_res   = 1'b1;
                            res.end_status = ST_RAN_OUT;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    remain_next       = rem_dec;
                    res_valid         = 1'b1;
                    res.fragment_byte = data_byte;
                    res.has_byte      = 1'b1;
                    if (rem_dec == 32'd0)
                    begin
                        res.fragment_end = 1'b1;
                        count_next       = cnt_inc;
                        phase_next       = PH_HEADER;
                        header_next      = '0;
                        hcount_next      = '0;
                        if (!left_ge8)
                        begin
                            phase_next     = PH_DONE;
                            res.done_res   = 1'b1;
                            res.end_status = ST_RAN_OUT;
                        end
                    end
                end
                default:
                begin
                    // idle or done: byte ignored
                    offset_next = offset_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_length_reg <= '0;
            phase_reg         <= PH_IDLE;
            header_reg        <= '0;
            hcount_reg        <= '0;
            offset_reg        <= '0;
            remain_reg        <= '0;
            first_reg         <= 1'b1;
            count_reg         <= '0;
        end
        else
        begin
            if (cfg_fire)
                region_length_reg <= cfg_data;
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                header_reg <= header_next;
                hcount_reg <= hcount_next;
                offset_reg <= offset_next;
                remain_reg <= remain_next;
                first_reg  <= first_next;
                count_reg  <= count_next;
            end
        end
    end

endmodule

>>> src/efd_out_reg.sv
module efd_out_reg
    import efd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    can_load,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

>>> src/encapsulated_fragment_deframer.sv
// Latency: a result appears in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; in_ready drops only while a held result waits
// on out_ready (single output register).
// Reset (rst_n, async, active low): region_length 0, parser idle, no result held;
// bytes are ignored until a word with region_start set.
module encapsulated_fragment_deframer
    import efd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        region_length,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               region_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         fragment_byte,
    output logic               has_byte,
    output logic [INDEX_W-1:0] fragment_index,
    output logic               fragment_end,
    output logic               done_res,
    output logic [1:0]         end_status
);

    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;

    efd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_fire     (cfg_valid && cfg_ready),
        .cfg_data     (region_length),
        .in_fire      (in_fire),
        .data_byte    (data_byte),
        .region_start (region_start),
        .res_valid    (res_valid),
        .res          (res)
    );

    efd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire && res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (in_ready),
        .out_res   (out_res)
    );

    assign fragment_byte  = out_res.fragment_byte;
    assign has_byte       = out_res.has_byte;
    assign fragment_index = out_res.fragment_index;
    assign fragment_end   = out_res.fragment_end;
    assign done_res       = out_res.done_res;
    assign end_status     = out_res.end_status;

    a_status_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> end_status == ST_DELIM)
        else $error("status set without done");

    a_byte_done_ran_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_byte && done_res |-> end_status == ST_RAN_OUT && fragment_end)
        else $error("byte with done must end fragment and report ran out");

    a_empty_fragment: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte && !done_res |-> fragment_end)
        else $error("byteless result is neither done nor empty fragment");

    a_byte_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> fragment_byte == 8'd0)
        else $error("fragment_byte set without has_byte");

endmodule

>>> tb/sv/encapsulated_fragment_deframer_tb.sv
module encapsulated_fragment_deframer_tb
    import efd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [31:0]        region_length = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         data_byte = '0;
    logic               region_start = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         fragment_byte;
    logic               has_byte;
    logic [INDEX_W-1:0] fragment_index;
    logic               fragment_end;
    logic               done_res;
    logic [1:0]         end_status;

    encapsulated_fragment_deframer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .region_length  (region_length),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .region_start   (region_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .fragment_byte  (fragment_byte),
        .has_byte       (has_byte),
        .fragment_index (fragment_index),
        .fragment_end   (fragment_end),
        .done_res       (done_res),
        .end_status     (end_status)
    );

    always #1 clk = ~clk;

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned errors = 0;
    int unsigned words_checked = 0;
    int unsigned sent_bytes = 0;
    int unsigned regions_run = 0;

    result_t     expected_words[$];
    logic [7:0]  region_bytes[$];

    // parser mirror
    logic [31:0]        rl_len = '0;
    phase_t             prs_phase = PH_IDLE;
    logic [63:0]        hdr_word = '0;
    int unsigned        hdr_count = 0;
    logic [31:0]        region_pos = '0;
    logic [31:0]        item_left = '0;
    logic               offset_table_due = 1'b1;
    logic [INDEX_W-1:0] frag_count = '0;

    function automatic logic [31:0] region_room();
        return (rl_len > region_pos) ? rl_len - region_pos : 32'd0;
    endfunction

    function automatic bit header_room();
        prs_phase = PH_HEADER;
        hdr_word = '0;
        hdr_count = 0;
        return region_room() >= 32'd8;
    endfunction

    function automatic result_t done_word(status_t s);
        result_t r;
        r = '0;
        prs_phase = PH_DONE;
        r.fragment_index = frag_count;
        r.done_res = 1'b1;
        r.end_status = s;
        return r;
    endfunction

    function automatic void bump_fragment();
        if (frag_count != '1)
            frag_count++;
    endfunction

    function automatic void add_region_byte(logic [7:0] v);
        region_bytes = {region_bytes, v};
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, input logic st, output result_t r);
        logic [15:0]        grp;
        logic [15:0]        elem;
        logic [31:0]        len;
        logic [INDEX_W-1:0] idx;
        bit                 more;
        r = '0;
        if (st)
        begin
            region_pos = '0;
            item_left = '0;
            offset_table_due = 1'b1;
            frag_count = '0;
            if (!header_room())
            begin
                r = done_word(ST_RAN_OUT);
                return 1;
            end
        end
        if (prs_phase != PH_HEADER && prs_phase != PH_SKIP && prs_phase != PH_PAYLOAD)
            return 0;
        region_pos++;

        if (prs_phase == PH_HEADER)
        begin
            hdr_word[8*hdr_count +: 8] = b;
            hdr_count++;
            if (hdr_count < 8)
                return 0;
            grp = hdr_word[15:0];
            elem = hdr_word[31:16];
            len = hdr_word[63:32];
            hdr_word = '0;
            hdr_count = 0;
            if (offset_table_due)
            begin
                offset_table_due = 1'b0;
                if (grp == TAG_GROUP && elem == TAG_ITEM)
                begin
                    if (len > region_room())
                    begin
                        r = done_word(ST_RAN_OUT);
                        return 1;
                    end
                    if (len == 0)
                    begin
                        if (!header_room())
                        begin
                            r = done_word(ST_RAN_OUT);
                            return 1;
                        end
                        return 0;
                    end
                    item_left = len;
                    prs_phase = PH_SKIP;
                    return 0;
                end
            end
            if (grp == TAG_GROUP && elem == TAG_SEQ_DELIM)
            begin
                r = done_word(ST_DELIM);
                return 1;
            end
            if (grp != TAG_GROUP || elem != TAG_ITEM)
            begin
                r = done_word(ST_BAD_TAG);
                return 1;
            end
            if (len > region_room())
            begin
                r = done_word(ST_TOO_LONG);
                return 1;
            end
            if (len == 0)
            begin
                idx = frag_count;
                bump_fragment();
                more = header_room();
                r.fragment_index = idx;
                r.fragment_end = 1'b1;
                if (!more)
                begin
                    prs_phase = PH_DONE;
                    r.done_res = 1'b1;
                    r.end_status = ST_RAN_OUT;
                end
                return 1;
            end
            item_left = len;
            prs_phase = PH_PAYLOAD;
            return 0;
        end

        if (prs_phase == PH_SKIP)
        begin
            if (item_left != 0)
                item_left--;
            if (item_left == 0 && !header_room())
            begin
                r = done_word(ST_RAN_OUT);
                return 1;
            end
            return 0;
        end

        idx = frag_count;
        if (item_left != 0)
            item_left--;
        r.fragment_byte = b;
        r.has_byte = 1'b1;
        r.fragment_index = idx;
        if (item_left == 0)
        begin
            r.fragment_end = 1'b1;
            bump_fragment();
            if (!header_room())
            begin
                prs_phase = PH_DONE;
                r.done_res = 1'b1;
                r.end_status = ST_RAN_OUT;
            end
        end
        return 1;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : word_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected word, expected none, actual byte %0h has %0b",
                         $time, fragment_byte, has_byte);
                $display("    idx %0h end %0b done %0b st %0d",
                         fragment_index, fragment_end, done_res, end_status);
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                check_field("fragment_byte", want.fragment_byte, fragment_byte);
                check_field("has_byte", want.has_byte, has_byte);
                check_field("fragment_index", want.fragment_index, fragment_index);
                check_field("fragment_end", want.fragment_end, fragment_end);
                check_field("done_res", want.done_res, done_res);
                check_field("end_status", want.end_status, end_status);
            end
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= sink_stall_pct);

    task automatic push_byte(logic [7:0] b, logic st);
        result_t r;
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        region_start <= st;
        do @(posedge clk); while (!in_ready);
        sent_bytes++;
        if (deframe_byte(b, st, r))
            expected_words = {expected_words, r};
    endtask

    task automatic settle();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_region_length(logic [31:0] v);
        settle();
        cfg_valid <= 1'b1;
        region_length <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rl_len = v;
    endtask

    function automatic void add_header(logic [15:0] g, logic [15:0] e, logic [31:0] l);
        for (int i = 0; i < 2; i++)
            add_region_byte(g[8*i +: 8]);
        for (int i = 0; i < 2; i++)
            add_region_byte(e[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            add_region_byte(l[8*i +: 8]);
    endfunction

    function automatic void add_payload(int unsigned n);
        repeat (n)
            add_region_byte(8'($urandom));
    endfunction

    task automatic send_region();
        foreach (region_bytes[i])
            push_byte(region_bytes[i], i == 0);
    endtask

    task automatic test_bytes_before_region();
        region_bytes = '{8'h00, 8'hFF, 8'hA5};
        foreach (region_bytes[i])
            push_byte(region_bytes[i], 1'b0);
    endtask

    task automatic test_short_region();
        write_region_length(32'd0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        write_region_length(32'd7);
        push_byte(8'h5A, 1'b1);
    endtask

    task automatic test_empty_offset_table();
        write_region_length(32'd8);
        region_bytes.delete();
        add_header(TAG_GROUP, TAG_ITEM, 32'd0);
        send_region();
    endtask

    task automatic test_first_header_delimiter();
        write_region_length(32'hFFFF_FFFF);
        region_bytes.delete();
        add_header(TAG_GROUP, TAG_SEQ_DELIM, 32'hFFFF_FFFF);
        send_region();
    endtask

    task automatic run_region();
        int unsigned shape;
        int unsigned n_frag;
        int unsigned term;
        int unsigned cut;
        int unsigned slack;
        logic [31:0] rlen;
        logic [31:0] tl;
        logic [15:0] g;
        logic [15:0] e;
        bit          ot_long;
        bit          relength;
        region_bytes.delete();
        ot_long = 1'b0;
        shape = $urandom_range(99);
        if (shape < 8)
        begin
            add_payload($urandom_range(8, 30));
            rlen = $urandom_range(0, 40);
        end
        else
        begin
            if (shape < 60)
            begin
                tl = $urandom_range(0, 6);
                add_header(TAG_GROUP, TAG_ITEM, tl);
                add_payload(tl);
            end
            else if (shape < 68)
            begin
                ot_long = 1'b1;
                add_header(TAG_GROUP, TAG_ITEM, 32'd0);
            end
            else if (shape < 75)
                add_header(16'($urandom), 16'($urandom), $urandom_range(0, 4));
            n_frag = $urandom_range(0, 4);
            repeat (n_frag)
            begin
                tl = ($urandom_range(4) == 0) ? 32'd0 : 32'($urandom_range(1, 10));
                add_header(TAG_GROUP, TAG_ITEM, tl);
                add_payload(tl);
            end
            term = $urandom_range(4);
            if (term == 2)
            begin
                slack = $urandom_range(0, 12);
                rlen = region_bytes.size() + 8 + slack;
                tl = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF
                                              : 32'(slack + 1 + $urandom_range(0, 3));
                add_header(TAG_GROUP, TAG_ITEM, tl);
            end
            else if (term >= 3)
                rlen = region_bytes.size() + $urandom_range(0, 7);
            else
            begin
                if (term == 0)
                    add_header(TAG_GROUP, TAG_SEQ_DELIM,
                               $urandom_range(1) ? 32'd0 : $urandom);
                else
                begin
                    case ($urandom_range(2))
                        0:
                        begin
                            g = 16'($urandom);
                            e = TAG_ITEM;
                        end
                        1:
                        begin
                            g = TAG_GROUP;
                            e = 16'($urandom);
                        end
                        default:
                        begin
                            g = 16'($urandom);
                            e = 16'($urandom);
                        end
                    endcase
                    add_header(g, e, $urandom);
                end
                case ($urandom_range(3))
                    0: rlen = region_bytes.size();
                    1: rlen = region_bytes.size() + $urandom_range(1, 20);
                    2: rlen = 32'hFFFF_FFFF;
                    default:
                    begin
                        rlen = $urandom;
                        if (rlen < region_bytes.size())
                            rlen = 32'hFFFF_FFFF - $urandom_range(0, 255);
                    end
                endcase
            end
            if (ot_long)
            begin
                tl = (rlen < 8 || rlen > 32'hFFFF_FFF0) ? 32'hFFFF_FFFF
                                                        : rlen - 7 + $urandom_range(0, 3);
                for (int i = 0; i < 4; i++)
                    region_bytes[4+i] = tl[8*i +: 8];
            end
            while (region_bytes.size() < rlen && region_bytes.size() < 64)
                add_payload(1);
        end
        add_payload($urandom_range(0, 3));

        write_region_length(rlen);
        regions_run++;
        cut = region_bytes.size();
        relength = 1'b0;
        if (region_bytes.size() > 2 && $urandom_range(99) < 12)
        begin
            cut = $urandom_range(1, region_bytes.size() - 1);
            relength = $urandom_range(1);
        end
        for (int i = 0; i < cut; i++)
            push_byte(region_bytes[i], i == 0);
        if (relength)
        begin
            write_region_length($urandom_range(1) ? 32'($urandom_range(0, cut + 24)) : $urandom);
            for (int i = cut; i < region_bytes.size(); i++)
                push_byte(region_bytes[i], 1'b0);
        end
    endtask

    task automatic test_random_regions(int unsigned idle, int unsigned stall, int unsigned quota);
        int unsigned stop_at;
        settle();
        src_idle_pct = idle;
        sink_stall_pct = stall;
        stop_at = sent_bytes + quota;
        while (sent_bytes < stop_at)
            run_region();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bytes_before_region();
        test_short_region();
        test_empty_offset_table();
        test_first_header_delimiter();

        test_random_regions(0, 0, 270);
        test_random_regions(51, 0, 270);
        test_random_regions(0, 51, 270);
        test_random_regions(24, 24, 270);

        settle();
        $display("Ran %0d random regions over %0d sent bytes; %0d result words checked",
                 regions_run, sent_bytes, words_checked);
        $display("under free-running, source-gapped, sink-stalled and mixed pacing.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Timeout with %0d words still expected", expected_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> encapsulated_fragment_deframer.f
src/efd_pkg.sv
src/efd_parser.sv
src/efd_out_reg.sv
src/encapsulated_fragment_deframer.sv
tb/sv/encapsulated_fragment_deframer_tb.sv
